[src/mpps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpps_pkg
// Shared codes and control types for the multi-policy process scheduler.
// ----------------------------------------------------------------------------
package mpps_pkg;

    // Slot life-cycle states as held in the process table.
    localparam logic [2:0] ST_UNUSED   = 3'd0;
    localparam logic [2:0] ST_EMBRYO   = 3'd1;
    localparam logic [2:0] ST_SLEEPING = 3'd2;
    localparam logic [2:0] ST_RUNNABLE = 3'd3;
    localparam logic [2:0] ST_RUNNING  = 3'd4;
    localparam logic [2:0] ST_ZOMBIE   = 3'd5;

    // Command codes.
    localparam logic [2:0] CMD_ALLOC  = 3'd0;
    localparam logic [2:0] CMD_RUN    = 3'd1;
    localparam logic [2:0] CMD_SETST  = 3'd2;
    localparam logic [2:0] CMD_SELECT = 3'd3;
    localparam logic [2:0] CMD_CHARGE = 3'd4;
    localparam logic [2:0] CMD_PRIO   = 3'd5;

    // Requested states for the set state command.
    localparam logic [1:0] NST_SLEEPING = 2'd0;
    localparam logic [1:0] NST_ZOMBIE   = 2'd1;
    localparam logic [1:0] NST_UNUSED   = 2'd2;
    localparam logic [1:0] NST_BAD      = 2'd3;

    // Result status codes.
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_NONE = 2'd1;
    localparam logic [1:0] STAT_BAD  = 2'd2;
    localparam logic [1:0] STAT_FULL = 2'd3;

    // Scheduling policies.
    localparam logic [1:0] POL_RR    = 2'd0;
    localparam logic [1:0] POL_FIFO  = 2'd1;
    localparam logic [1:0] POL_RATIO = 2'd2;
    localparam logic [1:0] POL_THREE = 2'd3;

    // Priority levels with a special meaning.
    localparam logic [1:0] PRIO_FIFO    = 2'd1;
    localparam logic [1:0] PRIO_TOP     = 2'd2;
    localparam logic [1:0] PRIO_INVALID = 2'd3;

    // Controls from the sequencer to the ratio compare unit.
    typedef struct packed {
        logic clear;
        logic load;
        logic mul;
        logic cmp;
    } rat_ctrl_t;

endpackage

[src/mpps_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpps_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mpps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/mpps_ratio.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpps_ratio
// Run/age ratio compare unit: age, cross-multiply and best-candidate tracking.
// ----------------------------------------------------------------------------
module mpps_ratio
    import mpps_pkg::*;
#(
    parameter int TW = 32,
    parameter int SB = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  rat_ctrl_t     ctrl,
    input  logic [TW-1:0] now,
    input  logic [TW-1:0] ctime,
    input  logic [TW-1:0] run,
    input  logic [SB-1:0] idx,
    output logic          found,
    output logic [SB-1:0] best_idx
);

    logic [TW-1:0]   age_wrap;
    logic [TW-1:0]   age_fix;
    logic [TW-1:0]   cand_age_reg;
    logic [TW-1:0]   cand_run_reg;
    logic [SB-1:0]   cand_idx_reg;
    logic [TW-1:0]   best_age_reg;
    logic [TW-1:0]   best_run_reg;
    logic [SB-1:0]   best_idx_reg;
    logic [2*TW-1:0] prod_a_reg;
    logic [2*TW-1:0] prod_b_reg;
    logic            found_reg;
    logic            better;

    // Age wraps modulo the time width; an age of zero counts as one.
    assign age_wrap = now - ctime;
    assign age_fix  = (age_wrap == '0) ? TW'(1) : age_wrap;

    // The candidate wins on a strictly smaller ratio, so ties keep the lower slot.
    assign better = !found_reg || (prod_a_reg < prod_b_reg);

    // Candidate, product and best registers.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cand_age_reg <= age_fix;
            cand_run_reg <= run;
            cand_idx_reg <= idx;
        end
        if (ctrl.mul)
        begin
            prod_a_reg <= {{TW{1'b0}}, cand_run_reg} * {{TW{1'b0}}, best_age_reg};
            prod_b_reg <= {{TW{1'b0}}, best_run_reg} * {{TW{1'b0}}, cand_age_reg};
        end
        if (ctrl.cmp && better)
        begin
            best_age_reg <= cand_age_reg;
            best_run_reg <= cand_run_reg;
            best_idx_reg <= cand_idx_reg;
        end
    end

    // Whether any candidate has been seen in the current scan.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            found_reg <= 1'b0;
        end
        else if (ctrl.cmp)
        begin
            found_reg <= 1'b1;
        end
    end

    assign found    = found_reg;
    assign best_idx = best_idx_reg;

endmodule

[src/multi_policy_process_scheduler_top.sv]
`timescale 1ns / 1ps
// Slot commands read the table entry, then check and write it; allocate and round robin
// select read and check one table entry at a time, bound by the table port. Lowest ratio
// scans age each slot and pass runnable ones through the multiplier and compare; a FIFO pop
// reads the head, then that slot; three level may run two ratio scans and a FIFO drain.
// One transaction at a time; done is a one-cycle strobe, the receiver cannot stall.
// Reset is asynchronous: valid bits clear at once so every slot reads unused, no sweep.
// ----------------------------------------------------------------------------
// multi_policy_process_scheduler_top
// Process table scheduler with round robin, FIFO, lowest ratio and three-level
// selection, built around a table RAM and a ready FIFO RAM.
// ----------------------------------------------------------------------------
module multi_policy_process_scheduler_top
    import mpps_pkg::*;
#(
    parameter int SLOTS     = 64,
    parameter int TIME_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  cmd,
    input  logic [5:0]  slot,
    input  logic [1:0]  new_state,
    input  logic [1:0]  level,
    input  logic [15:0] amount,
    input  logic [31:0] now,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    output logic        done,
    output logic [1:0]  status,
    output logic [5:0]  chosen_slot,
    output logic [15:0] proc_id
);

    localparam int SB = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int TW = TIME_BITS;
    localparam int WW = 21 + 2 * TW;
    localparam logic [SB-1:0] LAST_SLOT = SB'(SLOTS - 1);
    localparam logic [CW-1:0] LAST_CNT  = CW'(SLOTS - 1);

    typedef enum logic [14:0] {
        S_IDLE      = 15'b000000000000001,
        S_OP_RD     = 15'b000000000000010,
        S_OP_EX     = 15'b000000000000100,
        S_SCAN_RD   = 15'b000000000001000,
        S_SCAN_CHK  = 15'b000000000010000,
        S_RAT_RD    = 15'b000000000100000,
        S_RAT_AGE   = 15'b000000001000000,
        S_RAT_MUL   = 15'b000000010000000,
        S_RAT_CMP   = 15'b000000100000000,
        S_RAT_END   = 15'b000001000000000,
        S_FIFO_RD   = 15'b000010000000000,
        S_FIFO_CHK1 = 15'b000100000000000,
        S_FIFO_CHK2 = 15'b001000000000000,
        S_COMMIT_RD = 15'b010000000000000,
        S_COMMIT_WR = 15'b100000000000000
    } fsm_t;

    function automatic logic [SB-1:0] next_slot(input logic [SB-1:0] x);
        return (x == LAST_SLOT) ? '0 : x + 1'b1;
    endfunction

    fsm_t state_reg, state_next;

    // Command registers captured at acceptance.
    logic [2:0]    cmd_reg;
    logic [5:0]    slot_reg;
    logic [1:0]    nst_reg;
    logic [1:0]    level_reg;
    logic [15:0]   amount_reg;
    logic [TW-1:0] now_reg;

    logic [SB-1:0] scan_idx_reg, scan_idx_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [SB-1:0] pick_reg, pick_next;
    logic          only_top_reg, only_top_next;
    logic [SB-1:0] rr_reg, rr_next;
    logic [SB-1:0] head_reg, head_next;
    logic [SB-1:0] tail_reg, tail_next;
    logic [15:0]   next_id_reg, next_id_next;
    logic [1:0]    policy_reg;
    logic [SLOTS-1:0] valid_reg;
    logic          rd_valid_reg;

    logic          done_reg, done_next;
    logic [1:0]    status_reg, status_next;
    logic [SB-1:0] chosen_reg, chosen_next;
    logic [15:0]   id_reg, id_next;

    // Table RAM ports and field views.
    logic          tbl_we;
    logic [SB-1:0] tbl_waddr;
    logic [WW-1:0] tbl_wdata;
    logic [SB-1:0] tbl_raddr;
    logic [WW-1:0] tbl_rdata;
    logic [2:0]    w_state;
    logic [15:0]   w_id;
    logic [1:0]    w_prio;
    logic [TW-1:0] w_ctime;
    logic [TW-1:0] w_rtime;

    logic [2:0]    eff_state;
    logic [15:0]   eff_id;
    logic [1:0]    rd_prio;
    logic [TW-1:0] rd_ctime;
    logic [TW-1:0] rd_rtime;

    // FIFO RAM ports.
    logic          fifo_we;
    logic [SB-1:0] fifo_rdata;

    logic          in_range;
    logic [SB-1:0] slot_idx;
    logic          fifo_full;
    logic          fifo_empty;
    logic          cand;
    logic [TW:0]   charge_sum;
    rat_ctrl_t     rat_ctrl;
    logic          rat_found;
    logic [SB-1:0] rat_best;

    assign slot_idx   = SB'(slot_reg);
    assign in_range   = 32'(slot_reg) < SLOTS;
    assign fifo_full  = (next_slot(tail_reg) == head_reg);
    assign fifo_empty = (head_reg == tail_reg);

    // An entry that was never written reads as an unused slot with id zero.
    assign eff_state = rd_valid_reg ? tbl_rdata[WW-1 -: 3] : ST_UNUSED;
    assign eff_id    = rd_valid_reg ? tbl_rdata[WW-4 -: 16] : 16'd0;
    assign rd_prio   = tbl_rdata[2*TW+1 -: 2];
    assign rd_ctime  = tbl_rdata[2*TW-1 -: TW];
    assign rd_rtime  = tbl_rdata[TW-1:0];
    assign tbl_wdata = {w_state, w_id, w_prio, w_ctime, w_rtime};

    assign charge_sum = (TW+1)'(rd_rtime) + (TW+1)'(amount_reg);
    assign cand = (eff_state == ST_RUNNABLE) && (!only_top_reg || rd_prio == PRIO_TOP);

    // Ratio unit controls follow the scan states.
    always_comb
    begin
        rat_ctrl.clear = (state_reg == S_RAT_RD) && (cnt_reg == '0);
        rat_ctrl.load  = (state_reg == S_RAT_AGE) && cand;
        rat_ctrl.mul   = (state_reg == S_RAT_MUL);
        rat_ctrl.cmp   = (state_reg == S_RAT_CMP);
    end

    // Table read address selection.
    always_comb
    begin
        case (state_reg)
            S_OP_RD:     tbl_raddr = slot_idx;
            S_FIFO_CHK1: tbl_raddr = fifo_rdata;
            S_COMMIT_RD: tbl_raddr = pick_reg;
            default:     tbl_raddr = scan_idx_reg;
        endcase
    end

    mpps_ram #(
        .WIDTH(WW),
        .DEPTH(SLOTS)
    ) u_table (
        .clk  (clk),
        .we   (tbl_we),
        .waddr(tbl_waddr),
        .wdata(tbl_wdata),
        .raddr(tbl_raddr),
        .rdata(tbl_rdata)
    );

    mpps_ram #(
        .WIDTH(SB),
        .DEPTH(SLOTS)
    ) u_fifo (
        .clk  (clk),
        .we   (fifo_we),
        .waddr(tail_reg),
        .wdata(slot_idx),
        .raddr(head_reg),
        .rdata(fifo_rdata)
    );

    mpps_ratio #(
        .TW(TW),
        .SB(SB)
    ) u_ratio (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (rat_ctrl),
        .now     (now_reg),
        .ctime   (rd_ctime),
        .run     (rd_rtime),
        .idx     (scan_idx_reg),
        .found   (rat_found),
        .best_idx(rat_best)
    );

    // Sequencer: next state, table and FIFO writes, and result.
    always_comb
    begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        cnt_next      = cnt_reg;
        pick_next     = pick_reg;
        only_top_next = only_top_reg;
        rr_next       = rr_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        next_id_next  = next_id_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        chosen_next   = chosen_reg;
        id_next       = id_reg;
        tbl_we        = 1'b0;
        tbl_waddr     = slot_idx;
        w_state       = tbl_rdata[WW-1 -: 3];
        w_id          = tbl_rdata[WW-4 -: 16];
        w_prio        = rd_prio;
        w_ctime       = rd_ctime;
        w_rtime       = rd_rtime;
        fifo_we       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    scan_idx_next = '0;
                    cnt_next      = '0;
                    case (cmd)
                        CMD_ALLOC:
                        begin
                            state_next = S_SCAN_RD;
                        end
                        CMD_SELECT:
                        begin
                            case (policy_reg)
                                POL_RR:
                                begin
                                    scan_idx_next = rr_reg;
                                    state_next    = S_SCAN_RD;
                                end
                                POL_FIFO:
                                begin
                                    state_next = S_FIFO_RD;
                                end
                                POL_RATIO:
                                begin
                                    only_top_next = 1'b0;
                                    state_next    = S_RAT_RD;
                                end
                                default:
                                begin
                                    only_top_next = 1'b1;
                                    state_next    = S_RAT_RD;
                                end
                            endcase
                        end
                        CMD_RUN, CMD_SETST, CMD_CHARGE, CMD_PRIO:
                        begin
                            state_next = S_OP_RD;
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = STAT_BAD;
                            chosen_next = '0;
                            id_next     = '0;
                        end
                    endcase
                end
            end

            S_OP_RD:
            begin
                state_next = S_OP_EX;
            end

            S_OP_EX:
            begin
                state_next  = S_IDLE;
                done_next   = 1'b1;
                status_next = STAT_OK;
                chosen_next = slot_idx;
                id_next     = eff_id;
                case (cmd_reg)
                    CMD_RUN:
                    begin
                        if (!in_range || !(eff_state == ST_EMBRYO ||
                            eff_state == ST_SLEEPING || eff_state == ST_RUNNING))
                        begin
                            status_next = STAT_BAD;
                        end
                        else
                        begin
                            tbl_we  = 1'b1;
                            w_state = ST_RUNNABLE;
                            if (policy_reg == POL_FIFO ||
                                (policy_reg == POL_THREE && rd_prio == PRIO_FIFO))
                            begin
                                if (fifo_full)
                                begin
                                    status_next = STAT_FULL;
                                end
                                else
                                begin
                                    fifo_we   = 1'b1;
                                    tail_next = next_slot(tail_reg);
                                end
                            end
                        end
                    end
                    CMD_SETST:
                    begin
                        if (!in_range || nst_reg == NST_BAD ||
                            (nst_reg != NST_UNUSED && eff_state == ST_UNUSED))
                        begin
                            status_next = STAT_BAD;
                        end
                        else
                        begin
                            tbl_we = 1'b1;
                            case (nst_reg)
                                NST_SLEEPING: w_state = ST_SLEEPING;
                                NST_ZOMBIE:   w_state = ST_ZOMBIE;
                                default:
                                begin
                                    w_state = ST_UNUSED;
                                    w_id    = '0;
                                    id_next = '0;
                                end
                            endcase
                        end
                    end
                    CMD_CHARGE:
                    begin
                        if (!in_range || eff_state == ST_UNUSED)
                        begin
                            status_next = STAT_BAD;
                        end
                        else
                        begin
                            tbl_we  = 1'b1;
                            w_rtime = charge_sum[TW] ? '1 : charge_sum[TW-1:0];
                        end
                    end
                    default:
                    begin
                        if (!in_range || eff_state == ST_UNUSED || level_reg == PRIO_INVALID)
                        begin
                            status_next = STAT_BAD;
                        end
                        else
                        begin
                            tbl_we = 1'b1;
                            w_prio = level_reg;
                        end
                    end
                endcase
                if (status_next == STAT_BAD)
                begin
                    chosen_next = '0;
                    id_next     = '0;
                end
            end

            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end

            S_SCAN_CHK:
            begin
                if (cmd_reg == CMD_ALLOC && eff_state == ST_UNUSED)
                begin
                    // New process: embryo, fresh id, created now, priority two.
                    tbl_we       = 1'b1;
                    tbl_waddr    = scan_idx_reg;
                    w_state      = ST_EMBRYO;
                    w_id         = next_id_reg;
                    w_prio       = PRIO_TOP;
                    w_ctime      = now_reg;
                    w_rtime      = '0;
                    next_id_next = next_id_reg + 16'd1;
                    done_next    = 1'b1;
                    status_next  = STAT_OK;
                    chosen_next  = scan_idx_reg;
                    id_next      = next_id_reg;
                    state_next   = S_IDLE;
                end
                else if (cmd_reg != CMD_ALLOC && eff_state == ST_RUNNABLE)
                begin
                    rr_next    = next_slot(scan_idx_reg);
                    pick_next  = scan_idx_reg;
                    state_next = S_COMMIT_RD;
                end
                else if (cnt_reg == LAST_CNT)
                begin
                    done_next   = 1'b1;
                    status_next = STAT_NONE;
                    chosen_next = '0;
                    id_next     = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    scan_idx_next = next_slot(scan_idx_reg);
                    cnt_next      = cnt_reg + 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end

            S_RAT_RD:
            begin
                state_next = S_RAT_AGE;
            end

            S_RAT_AGE:
            begin
                if (cand)
                begin
                    state_next = S_RAT_MUL;
                end
                else if (cnt_reg == LAST_CNT)
                begin
                    state_next = S_RAT_END;
                end
                else
                begin
                    scan_idx_next = next_slot(scan_idx_reg);
                    cnt_next      = cnt_reg + 1'b1;
                    state_next    = S_RAT_RD;
                end
            end

            S_RAT_MUL:
            begin
                state_next = S_RAT_CMP;
            end

            S_RAT_CMP:
            begin
                if (cnt_reg == LAST_CNT)
                begin
                    state_next = S_RAT_END;
                end
                else
                begin
                    scan_idx_next = next_slot(scan_idx_reg);
                    cnt_next      = cnt_reg + 1'b1;
                    state_next    = S_RAT_RD;
                end
            end

            S_RAT_END:
            begin
                if (rat_found)
                begin
                    pick_next  = rat_best;
                    state_next = S_COMMIT_RD;
                end
                else if (only_top_reg)
                begin
                    state_next = S_FIFO_RD;
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = STAT_NONE;
                    chosen_next = '0;
                    id_next     = '0;
                    state_next  = S_IDLE;
                end
            end

            S_FIFO_RD:
            begin
                if (!fifo_empty)
                begin
                    state_next = S_FIFO_CHK1;
                end
                else if (policy_reg == POL_FIFO)
                begin
                    // Empty FIFO falls back to round robin.
                    scan_idx_next = rr_reg;
                    cnt_next      = '0;
                    state_next    = S_SCAN_RD;
                end
                else
                begin
                    // Third level: lowest ratio over every runnable slot.
                    only_top_next = 1'b0;
                    scan_idx_next = '0;
                    cnt_next      = '0;
                    state_next    = S_RAT_RD;
                end
            end

            S_FIFO_CHK1:
            begin
                head_next  = next_slot(head_reg);
                pick_next  = fifo_rdata;
                state_next = S_FIFO_CHK2;
            end

            S_FIFO_CHK2:
            begin
                // Stale entries whose slot is no longer runnable are discarded.
                state_next = (eff_state == ST_RUNNABLE) ? S_COMMIT_RD : S_FIFO_RD;
            end

            S_COMMIT_RD:
            begin
                state_next = S_COMMIT_WR;
            end

            S_COMMIT_WR:
            begin
                tbl_we      = 1'b1;
                tbl_waddr   = pick_reg;
                w_state     = ST_RUNNING;
                done_next   = 1'b1;
                status_next = STAT_OK;
                chosen_next = pick_reg;
                id_next     = eff_id;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            rr_reg       <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            next_id_reg  <= 16'd1;
            policy_reg   <= POL_RATIO;
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rr_reg       <= rr_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            next_id_reg  <= next_id_next;
            rd_valid_reg <= valid_reg[tbl_raddr];
            done_reg     <= done_next;
            if (tbl_we)
            begin
                valid_reg[tbl_waddr] <= 1'b1;
            end
            if (cfg_we)
            begin
                policy_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            cmd_reg    <= cmd;
            slot_reg   <= slot;
            nst_reg    <= new_state;
            level_reg  <= level;
            amount_reg <= amount;
            now_reg    <= now[TW-1:0];
        end
        scan_idx_reg <= scan_idx_next;
        cnt_reg      <= cnt_next;
        pick_reg     <= pick_next;
        only_top_reg <= only_top_next;
        status_reg   <= status_next;
        chosen_reg   <= chosen_next;
        id_reg       <= id_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign chosen_slot = 6'(chosen_reg);
    assign proc_id     = id_reg;

endmodule

[bench/tb_multi_policy_process_scheduler_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_policy_process_scheduler_top
// Self-checking bench for the process scheduler. A queue of commands feeds a
// driver; a scheduler model predicts every result and a monitor compares the
// strobed results with the predictions. The policy is changed between phases
// while the block is idle.
// ----------------------------------------------------------------------------
module tb_multi_policy_process_scheduler_top
    import mpps_pkg::*;
();

    localparam int NSLOT    = 64;
    localparam int WD_LIMIT = 20000;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [5:0]  slot;
        logic [1:0]  new_state;
        logic [1:0]  level;
        logic [15:0] amount;
        logic [31:0] now;
    } sched_cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  chosen_slot;
        logic [15:0] proc_id;
    } sched_res_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  cmd;
    logic [5:0]  slot;
    logic [1:0]  new_state;
    logic [1:0]  level;
    logic [15:0] amount;
    logic [31:0] now;
    logic        cfg_we;
    logic [1:0]  cfg_wdata;
    logic        done;
    logic [1:0]  status;
    logic [5:0]  chosen_slot;
    logic [15:0] proc_id;

    multi_policy_process_scheduler_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .slot(slot), .new_state(new_state), .level(level), .amount(amount),
        .now(now), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done),
        .status(status), .chosen_slot(chosen_slot), .proc_id(proc_id)
    );

    // Model state of the scheduler.
    logic [1:0]  m_policy;
    logic [2:0]  m_state [NSLOT];
    logic [15:0] m_id [NSLOT];
    logic [1:0]  m_prio [NSLOT];
    logic [31:0] m_born [NSLOT];
    logic [31:0] m_run [NSLOT];
    logic [5:0]  m_fifo [NSLOT];
    logic [5:0]  m_head;
    logic [5:0]  m_tail;
    logic [5:0]  m_rr;
    logic [15:0] m_next_id;

    sched_cmd_t  pending_cmds [$];
    sched_res_t  expected_results [$];
    int          errors;
    int          idle_cycles;
    int          gap;
    logic [31:0] tick;
    logic        busy_seen;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [63:0] age_of(int i, logic [31:0] t);
        logic [31:0] a;
        a = t - m_born[i];
        return (a == 32'd0) ? 64'd1 : {32'd0, a};
    endfunction

    function automatic int lowest_ratio(bit only_top, logic [31:0] t);
        int best;
        best = -1;
        for (int i = 0; i < NSLOT; i++)
        begin
            if (m_state[i] != ST_RUNNABLE) continue;
            if (only_top && m_prio[i] != PRIO_TOP) continue;
            if (best < 0 || {32'd0, m_run[i]} * age_of(best, t) <
                    {32'd0, m_run[best]} * age_of(i, t))
                best = i;
        end
        return best;
    endfunction

    function automatic int rr_pick();
        int i;
        for (int k = 0; k < NSLOT; k++)
        begin
            i = (m_rr + k) % NSLOT;
            if (m_state[i] == ST_RUNNABLE)
            begin
                m_rr = 6'(i + 1);
                return i;
            end
        end
        return -1;
    endfunction

    function automatic int fifo_pick();
        logic [5:0] s;
        while (m_head != m_tail)
        begin
            s = m_fifo[m_head];
            m_head = m_head + 6'd1;
            if (m_state[s] == ST_RUNNABLE) return int'(s);
        end
        return -1;
    endfunction

    // Work out the result of one command and update the model.
    function automatic sched_res_t predict_result(sched_cmd_t c);
        sched_res_t r;
        int pick;
        int s;
        bit ok;
        logic [32:0] sum;
        r = '0;
        pick = -1;
        s = c.slot;
        ok = (m_state[s] != ST_UNUSED);
        case (c.cmd)
            CMD_ALLOC:
            begin
                for (int i = 0; i < NSLOT; i++)
                    if (pick < 0 && m_state[i] == ST_UNUSED) pick = i;
                if (pick < 0)
                    r.status = STAT_NONE;
                else
                begin
                    m_state[pick] = ST_EMBRYO;
                    m_id[pick] = m_next_id;
                    m_next_id = m_next_id + 16'd1;
                    m_born[pick] = c.now;
                    m_run[pick] = '0;
                    m_prio[pick] = PRIO_TOP;
                end
            end
            CMD_RUN:
            begin
                if (m_state[s] != ST_EMBRYO && m_state[s] != ST_SLEEPING &&
                        m_state[s] != ST_RUNNING)
                    r.status = STAT_BAD;
                else
                begin
                    m_state[s] = ST_RUNNABLE;
                    if (m_policy == POL_FIFO ||
                            (m_policy == POL_THREE && m_prio[s] == PRIO_FIFO))
                    begin
                        if (m_tail + 6'd1 == m_head)
                            r.status = STAT_FULL;
                        else
                        begin
                            m_fifo[m_tail] = 6'(s);
                            m_tail = m_tail + 6'd1;
                        end
                    end
                    pick = s;
                end
            end
            CMD_SETST:
            begin
                if (c.new_state == NST_BAD || (c.new_state != NST_UNUSED && !ok))
                    r.status = STAT_BAD;
                else
                begin
                    if (c.new_state == NST_SLEEPING)
                        m_state[s] = ST_SLEEPING;
                    else if (c.new_state == NST_ZOMBIE)
                        m_state[s] = ST_ZOMBIE;
                    else
                    begin
                        m_state[s] = ST_UNUSED;
                        m_id[s] = '0;
                    end
                    pick = s;
                end
            end
            CMD_SELECT:
            begin
                case (m_policy)
                    POL_RR: pick = rr_pick();
                    POL_FIFO:
                    begin
                        pick = fifo_pick();
                        if (pick < 0) pick = rr_pick();
                    end
                    POL_RATIO: pick = lowest_ratio(1'b0, c.now);
                    default:
                    begin
                        pick = lowest_ratio(1'b1, c.now);
                        if (pick < 0) pick = fifo_pick();
                        if (pick < 0) pick = lowest_ratio(1'b0, c.now);
                    end
                endcase
                if (pick < 0)
                    r.status = STAT_NONE;
                else
                    m_state[pick] = ST_RUNNING;
            end
            CMD_CHARGE:
            begin
                if (!ok)
                    r.status = STAT_BAD;
                else
                begin
                    sum = {1'b0, m_run[s]} + {17'd0, c.amount};
                    m_run[s] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    pick = s;
                end
            end
            CMD_PRIO:
            begin
                if (!ok || c.level == PRIO_INVALID)
                    r.status = STAT_BAD;
                else
                begin
                    m_prio[s] = c.level;
                    pick = s;
                end
            end
            default: r.status = STAT_BAD;
        endcase
        if (pick >= 0 && (r.status == STAT_OK || r.status == STAT_FULL))
        begin
            r.chosen_slot = 6'(pick);
            r.proc_id = m_id[pick];
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    function automatic sched_cmd_t make_cmd(logic [2:0] c, logic [5:0] s,
            logic [1:0] ns, logic [1:0] lv, logic [15:0] am);
        sched_cmd_t x;
        x.cmd = c;
        x.slot = s;
        x.new_state = ns;
        x.level = lv;
        x.amount = am;
        tick = tick + 32'($urandom_range(0, 40));
        x.now = ($urandom_range(0, 30) == 0) ? 32'($urandom) : tick;
        return x;
    endfunction

    // Random command mix weighted towards well-formed slot life cycles.
    function automatic sched_cmd_t random_cmd(int few);
        int w;
        logic [5:0] s;
        w = $urandom_range(0, 99);
        s = (few != 0) ? 6'($urandom_range(0, 11)) : 6'($urandom);
        if (w < 15) return make_cmd(CMD_ALLOC, 6'($urandom), 2'($urandom), 2'($urandom),
                16'($urandom));
        if (w < 35) return make_cmd(CMD_RUN, s, 2'($urandom), 2'($urandom), 16'($urandom));
        if (w < 55) return make_cmd(CMD_SELECT, 6'($urandom), 2'($urandom), 2'($urandom),
                16'($urandom));
        if (w < 68) return make_cmd(CMD_CHARGE, s, 2'($urandom), 2'($urandom),
                ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom));
        if (w < 80) return make_cmd(CMD_PRIO, s, 2'($urandom), 2'($urandom), 16'($urandom));
        if (w < 96) return make_cmd(CMD_SETST, s, 2'($urandom), 2'($urandom),
                16'($urandom));
        return make_cmd(3'($urandom_range(6, 7)), s, 2'($urandom), 2'($urandom),
                16'($urandom));
    endfunction

    // Driver: one transaction per queued command, with a random gap before each.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd <= '0;
            slot <= '0;
            new_state <= '0;
            level <= '0;
            amount <= '0;
            now <= '0;
            gap <= 0;
        end
        else if (start && !busy_seen)
        begin
            start <= 1'b0;
            gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
        end
        else if (!start && pending_cmds.size() > 0 && !cfg_we)
        begin
            if (gap > 0)
                gap <= gap - 1;
            else
            begin
                cmd <= pending_cmds[0].cmd;
                slot <= pending_cmds[0].slot;
                new_state <= pending_cmds[0].new_state;
                level <= pending_cmds[0].level;
                amount <= pending_cmds[0].amount;
                now <= pending_cmds[0].now;
                start <= 1'b1;
            end
        end
    end

    // Acceptance seen at the rising edge; the driver lowers start after it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_seen <= 1'b1;
        else if (start && !busy)
        begin
            busy_seen <= 1'b0;
            expected_results.push_back(predict_result(pending_cmds.pop_front()));
        end
        else
            busy_seen <= 1'b1;
    end

    // Monitor: compare each strobed result with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("results waiting", 1, 0);
            end
            else
            begin
                if (status != expected_results[0].status)
                    report_mismatch("status", status, expected_results[0].status);
                if (chosen_slot != expected_results[0].chosen_slot)
                    report_mismatch("chosen_slot", chosen_slot,
                            expected_results[0].chosen_slot);
                if (proc_id != expected_results[0].proc_id)
                    report_mismatch("proc_id", proc_id, expected_results[0].proc_id);
                void'(expected_results.pop_front());
            end
        end
    end

    // Watchdog: ends the run after a long stretch with no transaction.
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_cmds.size() > 0 || expected_results.size() > 0 || start)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_policy(logic [1:0] p);
        @(negedge clk);
        cfg_wdata <= p;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        m_policy = p;
    endtask

    // Stimulus and end of run.
    initial
    begin
        logic [1:0] policies [8];
        policies = '{POL_RR, POL_THREE, POL_FIFO, POL_RATIO, POL_THREE, POL_RR,
                POL_FIFO, POL_THREE};
        errors = 0;
        tick = 32'd100;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        m_policy = POL_RATIO;
        for (int i = 0; i < NSLOT; i++)
        begin
            m_state[i] = ST_UNUSED;
            m_id[i] = '0;
            m_prio[i] = '0;
            m_born[i] = '0;
            m_run[i] = '0;
            m_fifo[i] = '0;
        end
        m_head = '0;
        m_tail = '0;
        m_rr = '0;
        m_next_id = 16'd1;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part under the reset policy: empty table, bad codes, extremes.
        pending_cmds.push_back(make_cmd(CMD_SELECT, 6'd0, 2'd0, 2'd0, 16'd0));
        pending_cmds.push_back(make_cmd(CMD_CHARGE, 6'd63, 2'd0, 2'd0, 16'hFFFF));
        pending_cmds.push_back(make_cmd(CMD_SETST, 6'd5, NST_SLEEPING, 2'd0, 16'd0));
        pending_cmds.push_back(make_cmd(CMD_SETST, 6'd5, NST_UNUSED, 2'd0, 16'd0));
        pending_cmds.push_back(make_cmd(CMD_ALLOC, 6'd0, 2'd0, 2'd0, 16'd0));
        pending_cmds.push_back(make_cmd(CMD_ALLOC, 6'd0, 2'd0, 2'd0, 16'd0));
        pending_cmds.push_back(make_cmd(CMD_RUN, 6'd0, 2'd0, 2'd0, 16'd0));
        pending_cmds.push_back(make_cmd(CMD_RUN, 6'd1, 2'd0, 2'd0, 16'd0));
        pending_cmds.push_back(make_cmd(CMD_CHARGE, 6'd0, 2'd0, 2'd0, 16'hFFFF));
        pending_cmds.push_back(make_cmd(CMD_PRIO, 6'd1, 2'd0, PRIO_INVALID, 16'd0));
        pending_cmds.push_back(make_cmd(CMD_PRIO, 6'd1, 2'd0, 2'd0, 16'd0));
        pending_cmds.push_back(make_cmd(CMD_SELECT, 6'd0, 2'd0, 2'd0, 16'd0));
        pending_cmds.push_back(make_cmd(CMD_RUN, 6'd1, 2'd0, 2'd0, 16'd0));
        pending_cmds.push_back(make_cmd(CMD_SETST, 6'd1, NST_BAD, 2'd0, 16'd0));
        pending_cmds.push_back(make_cmd(CMD_SETST, 6'd1, NST_ZOMBIE, 2'd0, 16'd0));
        pending_cmds.push_back(make_cmd(CMD_RUN, 6'd1, 2'd0, 2'd0, 16'd0));
        pending_cmds.push_back(make_cmd(3'd6, 6'd0, 2'd0, 2'd0, 16'd0));
        pending_cmds.push_back(make_cmd(3'd7, 6'd63, 2'd3, 2'd3, 16'hFFFF));
        for (int i = 0; i < 3; i++)
            pending_cmds.push_back(make_cmd(CMD_ALLOC, 6'd0, 2'd0, 2'd0, 16'd0));
        wait_idle();

        // Random phases; one phase fills the table and overflows the FIFO.
        for (int ph = 0; ph < 8; ph++)
        begin
            write_policy(policies[ph]);
            if (ph == 2)
            begin
                for (int i = 0; i < 66; i++)
                    pending_cmds.push_back(make_cmd(CMD_ALLOC, 6'd0, 2'd0, 2'd0, 16'd0));
                for (int i = 0; i < 64; i++)
                    pending_cmds.push_back(make_cmd(CMD_RUN, 6'(i), 2'd0, 2'd0, 16'd0));
            end
            for (int i = 0; i < 200; i++)
                pending_cmds.push_back(random_cmd(ph % 2));
            wait_idle();
        end

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
src/mpps_pkg.sv
src/mpps_ram.sv
src/mpps_ratio.sv
src/multi_policy_process_scheduler_top.sv
bench/tb_multi_policy_process_scheduler_top.sv
